// File: sv/hgscc_pkg.sv
`default_nettype none
package hgscc_pkg;
    localparam int VW = 6;
endpackage
`default_nettype wire

// File: sv/hgscc_ram.sv
`default_nettype none
module hgscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: sv/head_graph_scc_finder_core.sv
`default_nettype none
// Strongly connected components of a dependency head graph. Heads are loaded one item
// per cycle (s_axis_tdata[5:0] = head, s_axis_tlast = last token); token t gets an edge
// from its head, vertex 0 is the root, a head above the final token count gives no edge
// and tokens past MAX_VERTICES-1 are dropped. The last item starts a Tarjan search with
// explicit stacks; each vertex is then emitted in pop order with its component number
// (m_axis_tdata: vertex[5:0], component[11:6]; m_axis_tuser: component_end;
// m_axis_tlast = final result). The state lives in four memories: heads, vertex records
// (order and on-stack flag), call frames and the vertex stack. The search checks each start
// vertex, scans every (vertex, token) pair, pops each vertex and returns from each visited
// vertex; a pending result waits on m_axis_tready. No item is accepted while the search runs.
module head_graph_scc_finder_core #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // head[5:0], zero fill
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // vertex[5:0], component[11:6], zero fill
    output logic             m_axis_tuser,   // component_end
    output logic             m_axis_tlast
);
    localparam int VW = hgscc_pkg::VW;
    localparam int HW = VW + 1;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int OW = AW + 1;
    localparam int FW = AW + 3 * OW;   // frame: vertex, scan, order, low link
    localparam logic [OW-1:0] UNV = OW'(MAX_VERTICES);
    localparam logic [OW-1:0] MAXT = OW'(MAX_VERTICES - 1);

    localparam logic [3:0] S_LOAD = 4'd0, S_START = 4'd1, S_SCHK = 4'd2, S_SCAN = 4'd3,
        S_CHK = 4'd4, S_POP = 4'd5, S_POPW = 4'd6, S_RET = 4'd7, S_RETW = 4'd8;

    logic [3:0] st_reg, st_next;
    logic [OW-1:0] tc_reg, s_reg, j_reg, no_reg, sd_reg, fd_reg, oc_reg;
    logic [OW-1:0] vord_reg, vlow_reg;
    logic [AW-1:0] v_reg, cc_reg;
    logic mv_reg, mend_reg, mlast_reg;
    logic [AW-1:0] mw_reg, mc_reg;

    // memories
    logic h_we; logic [AW-1:0] h_wa, h_ra; logic [VW-1:0] h_wd, h_rd;
    logic r_we; logic [AW-1:0] r_wa, r_ra; logic [OW:0] r_wd, r_rd;
    logic f_we; logic [AW-1:0] f_wa, f_ra; logic [FW-1:0] f_wd, f_rd;
    logic k_we; logic [AW-1:0] k_wa, k_ra; logic [AW-1:0] k_wd, k_rd;

    hgscc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_head (.aclk(aclk), .we(h_we),
        .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    hgscc_ram #(.WIDTH(OW+1), .DEPTH(MAX_VERTICES)) u_rec (.aclk(aclk), .we(r_we),
        .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
    hgscc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_call (.aclk(aclk), .we(f_we),
        .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
    hgscc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_stk (.aclk(aclk), .we(k_we),
        .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

    logic acc, fire, link_w, r_on_w;
    logic [OW-1:0] n_w, r_ord_w;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (st_reg == S_LOAD);
    assign n_w = tc_reg + OW'(1);
    assign r_ord_w = r_rd[OW:1];
    assign r_on_w = r_rd[0];
    // heads above the token count can never equal a vertex
    assign link_w = ({1'b0, h_rd} == HW'(v_reg));
    assign fire = (st_reg == S_POPW) && (!mv_reg || m_axis_tready);

    always_comb begin
        st_next = st_reg;
        h_we = 1'b0;
        h_wa = AW'(tc_reg + OW'(1));
        h_wd = s_axis_tdata[VW-1:0];
        h_ra = j_reg[AW-1:0];
        r_we = 1'b0;
        r_wa = j_reg[AW-1:0];
        r_wd = {no_reg, 1'b1};
        r_ra = (st_reg == S_START) ? s_reg[AW-1:0] : j_reg[AW-1:0];
        f_we = 1'b0;
        f_wa = fd_reg[AW-1:0];
        f_wd = {v_reg, j_reg + OW'(1), vord_reg, vlow_reg};
        f_ra = AW'(fd_reg - OW'(1));
        k_we = 1'b0;
        k_wa = sd_reg[AW-1:0];
        k_wd = j_reg[AW-1:0];
        k_ra = AW'(sd_reg - OW'(1));
        unique case (st_reg)
            S_LOAD: if (acc) begin
                // token t lands at vertex t, marked unvisited
                h_we = (tc_reg < MAXT);
                r_we = (tc_reg < MAXT);
                r_wa = AW'(tc_reg + OW'(1));
                r_wd = {UNV, 1'b0};
                if (s_axis_tlast) st_next = S_START;
            end
            S_START: st_next = (s_reg == n_w) ? S_LOAD : S_SCHK;
            S_SCHK: begin
                // the root record is never loaded, it is always the first start
                if (s_reg == '0 || r_ord_w == UNV) begin
                    r_we = 1'b1; r_wa = s_reg[AW-1:0];
                    k_we = 1'b1; k_wd = s_reg[AW-1:0];
                    st_next = S_SCAN;
                end else st_next = S_START;
            end
            S_SCAN: begin
                if (j_reg < n_w) st_next = S_CHK;
                else if (vlow_reg == vord_reg) st_next = S_POP;
                else st_next = S_RET;
            end
            S_CHK: begin
                if (link_w && r_ord_w == UNV) begin
                    f_we = 1'b1;
                    r_we = 1'b1;
                    k_we = 1'b1;
                end
                st_next = S_SCAN;
            end
            S_POP: st_next = S_POPW;
            S_POPW: if (fire) begin
                // popped: visited, off the stack
                r_we = 1'b1; r_wa = k_rd; r_wd = {OW'(0), 1'b0};
                st_next = (k_rd == v_reg) ? S_RET : S_POP;
            end
            S_RET: st_next = (fd_reg == '0) ? S_START : S_RETW;
            S_RETW: st_next = S_SCAN;
            default: st_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_LOAD;
            tc_reg <= '0; s_reg <= '0; j_reg <= '0; no_reg <= '0; sd_reg <= '0;
            fd_reg <= '0; oc_reg <= '0; cc_reg <= '0; v_reg <= '0;
            vord_reg <= '0; vlow_reg <= '0;
            mv_reg <= 1'b0; mend_reg <= 1'b0; mlast_reg <= 1'b0;
            mw_reg <= '0; mc_reg <= '0;
        end else begin
            st_reg <= st_next;
            mv_reg <= fire || (mv_reg && !m_axis_tready);
            unique case (st_reg)
                S_LOAD: if (acc && tc_reg < MAXT) tc_reg <= tc_reg + OW'(1);
                S_START: if (s_reg == n_w) begin
                    tc_reg <= '0; s_reg <= '0; no_reg <= '0; oc_reg <= '0; cc_reg <= '0;
                end
                S_SCHK: begin
                    s_reg <= s_reg + OW'(1);
                    if (s_reg == '0 || r_ord_w == UNV) begin
                        v_reg <= s_reg[AW-1:0]; j_reg <= OW'(1);
                        vord_reg <= no_reg; vlow_reg <= no_reg;
                        no_reg <= no_reg + OW'(1);
                        sd_reg <= sd_reg + OW'(1);
                    end
                end
                S_SCAN: ;
                S_CHK: begin
                    if (link_w && r_ord_w == UNV) begin
                        // parent frame saved, child becomes the top frame
                        v_reg <= j_reg[AW-1:0]; j_reg <= OW'(1);
                        vord_reg <= no_reg; vlow_reg <= no_reg;
                        no_reg <= no_reg + OW'(1);
                        sd_reg <= sd_reg + OW'(1);
                        fd_reg <= fd_reg + OW'(1);
                    end else begin
                        j_reg <= j_reg + OW'(1);
                        if (link_w && r_on_w && r_ord_w < vlow_reg) vlow_reg <= r_ord_w;
                    end
                end
                S_POP: ;
                S_POPW: if (fire) begin
                    mw_reg <= k_rd; mc_reg <= cc_reg; mend_reg <= (k_rd == v_reg);
                    // every vertex is popped once, so the last one is number tc
                    mlast_reg <= (oc_reg == tc_reg);
                    oc_reg <= oc_reg + OW'(1);
                    sd_reg <= sd_reg - OW'(1);
                    if (k_rd == v_reg) cc_reg <= cc_reg + AW'(1);
                end
                S_RET: ;
                S_RETW: begin
                    v_reg <= f_rd[FW-1 -: AW];
                    j_reg <= f_rd[3*OW-1 -: OW];
                    vord_reg <= f_rd[2*OW-1 -: OW];
                    vlow_reg <= (vlow_reg < f_rd[OW-1:0]) ? vlow_reg : f_rd[OW-1:0];
                    fd_reg <= fd_reg - OW'(1);
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata = {{(16 - 2 * VW){1'b0}}, VW'(mc_reg), VW'(mw_reg)};
    assign m_axis_tuser = mend_reg;
    assign m_axis_tlast = mlast_reg;
endmodule
`default_nettype wire
